### src/timed_weighted_random_selector_defines.svh
// assertion macros for the timed weighted random selector checker
`ifndef TIMED_WEIGHTED_RANDOM_SELECTOR_DEFINES_SVH
`define TIMED_WEIGHTED_RANDOM_SELECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TWRS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TWRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tws_pkg.sv
// shared types and constants of the timed weighted random selector
`timescale 1ns / 1ps

package tws_pkg;

    localparam int CLASS_W         = 5;
    localparam int WEIGHT_W        = 16;
    localparam int PERIOD_W        = 16;
    localparam int RAND_W          = 32;
    localparam int KIND_W          = 2;
    localparam int INDEX_W         = 5;
    localparam int NUM_CLASSES_DEF = 19;

    localparam logic [WEIGHT_W-1:0] WEIGHT_UNIT  = 16'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_PICK
    } state_t;

    typedef struct packed {
        logic accept;
        logic sum_step;
        logic div_step;
        logic pick_step;
        logic emit_idle;
        logic emit_pick;
    } ctrl_cmd_t;

    typedef struct packed {
        logic expire_now;
        logic idx_last;
        logic sum_zero;
        logic div_last;
        logic pick_hit;
    } ctrl_sts_t;

endpackage

### src/timed_weighted_random_selector.sv
// top level of the timed weighted random selector
`timescale 1ns / 1ps

// One result beat per accepted item, on done for a single cycle; the receiver
// cannot stall it. Set, clear, unused kinds and ticks that do not end a period
// are finished at the accepting edge: their result is registered, shows in the
// next cycle, and busy stays low, so such items may come every cycle. A tick
// that ends the period runs a sequence: a sum walk over the weight table, a
// restoring modulo of the 32-bit random word by the sum (one bit per step) and
// a pick walk that stops at the hit or at the last class; busy is high
// meanwhile. When all weights are zero the modulo and the pick walk are
// skipped and class 0 is given. The table walks read one weight per cycle.
// tick_period may be written only while busy is low and no beat is pending.
module timed_weighted_random_selector #(
    parameter int NUM_CLASSES = tws_pkg::NUM_CLASSES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tws_pkg::KIND_W-1:0]    kind,
    input  logic [tws_pkg::INDEX_W-1:0]   weight_index,
    input  logic [tws_pkg::WEIGHT_W-1:0]  weight_value,
    input  logic [tws_pkg::RAND_W-1:0]    random_word,
    input  logic                          cfg_we,
    input  logic [tws_pkg::PERIOD_W-1:0]  cfg_wdata,
    output logic                          done,
    output logic                          expired,
    output logic [tws_pkg::CLASS_W-1:0]   chosen_class,
    output logic                          class_changed
);

    tws_pkg::ctrl_cmd_t cmd;
    tws_pkg::ctrl_sts_t sts;

    tws_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    tws_datapath #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .weight_index  (weight_index),
        .weight_value  (weight_value),
        .random_word   (random_word),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .expired       (expired),
        .chosen_class  (chosen_class),
        .class_changed (class_changed)
    );

endmodule

### src/tws_ctrl.sv
// sequencer for sum walk, modulo reduction and pick walk
`timescale 1ns / 1ps

module tws_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tws_pkg::ctrl_sts_t sts,
    output tws_pkg::ctrl_cmd_t cmd,
    output logic               busy
);

    tws_pkg::state_t state_reg;
    tws_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tws_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tws_pkg::ST_IDLE:
            begin
                if (start && sts.expire_now)
                begin
                    state_next = tws_pkg::ST_SUM;
                end
            end
            tws_pkg::ST_SUM:
            begin
                if (sts.idx_last)
                begin
                    state_next = sts.sum_zero ? tws_pkg::ST_IDLE : tws_pkg::ST_DIV;
                end
            end
            tws_pkg::ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = tws_pkg::ST_PICK;
                end
            end
            tws_pkg::ST_PICK:
            begin
                if (sts.pick_hit || sts.idx_last)
                begin
                    state_next = tws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tws_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            tws_pkg::ST_IDLE:
            begin
                busy           = 1'b0;
                cmd.accept     = start;
                cmd.emit_idle  = start && !sts.expire_now;
            end
            tws_pkg::ST_SUM:
            begin
                cmd.sum_step  = 1'b1;
                // empty table: class 0 without dividing
                cmd.emit_pick = sts.idx_last && sts.sum_zero;
            end
            tws_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            tws_pkg::ST_PICK:
            begin
                cmd.pick_step = 1'b1;
                cmd.emit_pick = sts.pick_hit || sts.idx_last;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### src/tws_datapath.sv
// weight table, tick timer, weight sum, modulo unit and pick walk
`timescale 1ns / 1ps

module tws_datapath #(
    parameter int NUM_CLASSES = tws_pkg::NUM_CLASSES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tws_pkg::ctrl_cmd_t            cmd,
    output tws_pkg::ctrl_sts_t            sts,
    input  logic [tws_pkg::KIND_W-1:0]    kind,
    input  logic [tws_pkg::INDEX_W-1:0]   weight_index,
    input  logic [tws_pkg::WEIGHT_W-1:0]  weight_value,
    input  logic [tws_pkg::RAND_W-1:0]    random_word,
    input  logic                          cfg_we,
    input  logic [tws_pkg::PERIOD_W-1:0]  cfg_wdata,
    output logic                          done,
    output logic                          expired,
    output logic [tws_pkg::CLASS_W-1:0]   chosen_class,
    output logic                          class_changed
);

    localparam int IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SUM_W = tws_pkg::WEIGHT_W + IDX_W;
    localparam int CNT_W = $clog2(tws_pkg::RAND_W);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CLASSES - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tws_pkg::RAND_W - 1);
    localparam logic [tws_pkg::INDEX_W:0] NUM_CLS = (tws_pkg::INDEX_W + 1)'(NUM_CLASSES);

    logic [tws_pkg::WEIGHT_W-1:0] weight_reg [NUM_CLASSES];
    logic [tws_pkg::PERIOD_W-1:0] period_reg;
    logic [tws_pkg::PERIOD_W-1:0] count_reg;
    logic [tws_pkg::CLASS_W-1:0]  current_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic [SUM_W-1:0]             rem_reg;
    logic [tws_pkg::RAND_W-1:0]   dvd_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [SUM_W-1:0]             acc_reg;
    logic                         done_reg;
    logic                         expired_reg;
    logic [tws_pkg::CLASS_W-1:0]  chosen_reg;
    logic                         changed_reg;

    logic [tws_pkg::WEIGHT_W-1:0] w_cur;
    logic [tws_pkg::PERIOD_W:0]   count_inc;
    logic [SUM_W-1:0]             sum_next;
    logic [SUM_W:0]               trial;
    logic                         trial_ge;
    logic [SUM_W:0]               trial_sub;
    logic [SUM_W-1:0]             acc_next;
    logic                         hit;
    logic [tws_pkg::CLASS_W-1:0]  pick_cls;
    logic                         set_ok;

    assign w_cur     = weight_reg[idx_reg];
    assign count_inc = {1'b0, count_reg} + {{tws_pkg::PERIOD_W{1'b0}}, 1'b1};
    assign sum_next  = sum_reg + SUM_W'(w_cur);
    // restoring step: shift one dividend bit into the remainder
    assign trial     = {rem_reg, dvd_reg[tws_pkg::RAND_W-1]};
    assign trial_ge  = trial >= {1'b0, sum_reg};
    assign trial_sub = trial - {1'b0, sum_reg};
    assign acc_next  = acc_reg + SUM_W'(w_cur);
    assign hit       = (w_cur != '0) && (rem_reg <= acc_next);
    assign pick_cls  = (cmd.pick_step && hit) ? tws_pkg::CLASS_W'(idx_reg) : '0;
    assign set_ok    = {1'b0, weight_index} < NUM_CLS;

    always_comb
    begin
        sts.expire_now = (tws_pkg::kind_t'(kind) == tws_pkg::KIND_TICK)
                         && (count_inc >= {1'b0, period_reg});
        sts.idx_last   = idx_reg == IDX_LAST;
        sts.sum_zero   = sum_next == '0;
        sts.div_last   = cnt_reg == CNT_LAST;
        sts.pick_hit   = hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                weight_reg[i] <= (i == 0) ? tws_pkg::WEIGHT_UNIT : '0;
            end
            period_reg  <= tws_pkg::PERIOD_RESET;
            count_reg   <= '0;
            current_reg <= '0;
            idx_reg     <= '0;
            sum_reg     <= '0;
            rem_reg     <= '0;
            dvd_reg     <= '0;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            done_reg    <= 1'b0;
            expired_reg <= 1'b0;
            chosen_reg  <= '0;
            changed_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end

            if (cmd.accept)
            begin
                idx_reg <= '0;
                sum_reg <= '0;
                acc_reg <= '0;
                rem_reg <= '0;
                cnt_reg <= '0;
                dvd_reg <= random_word;
                case (tws_pkg::kind_t'(kind))
                    tws_pkg::KIND_TICK:
                    begin
                        count_reg <= sts.expire_now ? '0 : count_inc[tws_pkg::PERIOD_W-1:0];
                    end
                    tws_pkg::KIND_SET:
                    begin
                        if (set_ok)
                        begin
                            weight_reg[weight_index[IDX_W-1:0]] <= weight_value;
                        end
                    end
                    tws_pkg::KIND_CLEAR:
                    begin
                        for (int i = 0; i < NUM_CLASSES; i++)
                        begin
                            weight_reg[i] <= '0;
                        end
                    end
                    default:
                    begin
                        count_reg <= count_reg;
                    end
                endcase
            end

            if (cmd.sum_step || cmd.pick_step)
            begin
                idx_reg <= (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
            end
            if (cmd.sum_step)
            begin
                sum_reg <= sum_next;
            end
            if (cmd.pick_step)
            begin
                acc_reg <= acc_next;
            end
            if (cmd.div_step)
            begin
                rem_reg <= trial_ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
                dvd_reg <= {dvd_reg[tws_pkg::RAND_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            done_reg <= cmd.emit_idle || cmd.emit_pick;
            if (cmd.emit_idle)
            begin
                expired_reg <= 1'b0;
                chosen_reg  <= current_reg;
                changed_reg <= 1'b0;
            end
            else if (cmd.emit_pick)
            begin
                expired_reg <= 1'b1;
                chosen_reg  <= pick_cls;
                changed_reg <= pick_cls != current_reg;
                current_reg <= pick_cls;
            end
        end
    end

    assign done          = done_reg;
    assign expired       = expired_reg;
    assign chosen_class  = chosen_reg;
    assign class_changed = changed_reg;

endmodule

### src/tws_checker.sv
// port-level checker for the timed weighted random selector, bound to the top
`timescale 1ns / 1ps
`include "timed_weighted_random_selector_defines.svh"

module tws_checker #(
    parameter int NUM_CLASSES = tws_pkg::NUM_CLASSES_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        expired,
    input logic [tws_pkg::CLASS_W-1:0] chosen_class,
    input logic                        class_changed
);

    localparam logic [tws_pkg::CLASS_W:0] NUM_CLS = (tws_pkg::CLASS_W + 1)'(NUM_CLASSES);

    // an accepted item either answers next cycle or keeps the block busy
    `TWRS_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "item lost after accept")

    // a selection run ends only with its result beat
    `TWRS_ASSERT_IMPL(a_busy_fall_done, $fell(busy), done && expired, "busy fell without a pick")

    `TWRS_ASSERT_IMPL(a_done_not_busy, done, !busy, "result beat while busy")

    `TWRS_ASSERT_IMPL(a_no_change_idle, done && !expired, !class_changed, "change without expiry")

    `TWRS_ASSERT_IMPL(a_class_range, done, {1'b0, chosen_class} < NUM_CLS, "class out of range")

endmodule

bind timed_weighted_random_selector tws_checker #(
    .NUM_CLASSES (NUM_CLASSES)
) u_tws_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .expired       (expired),
    .chosen_class  (chosen_class),
    .class_changed (class_changed)
);

### bench/timed_weighted_random_selector_test.sv
// self-checking bench for the timed weighted random selector: queued commands, predicted picks
`timescale 1ns / 1ps

module timed_weighted_random_selector_test;
    import tws_pkg::*;

    localparam int NUM_CLASSES = NUM_CLASSES_DEF;
    // kind code that the block leaves without effect
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int IDLE_PCT = 27;
    localparam int DRAIN_CYCLES = 2 * NUM_CLASSES + 40;
    localparam int MAX_PRINTED = 100;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [INDEX_W-1:0]  idx;
        logic [WEIGHT_W-1:0] wval;
        logic [RAND_W-1:0]   rnd;
    } sel_cmd_t;

    typedef struct {
        logic               expired;
        logic [CLASS_W-1:0] cls;
        logic               changed;
    } outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [KIND_W-1:0]   kind = '0;
    logic [INDEX_W-1:0]  weight_index = '0;
    logic [WEIGHT_W-1:0] weight_value = '0;
    logic [RAND_W-1:0]   random_word = '0;
    logic                cfg_we = 1'b0;
    logic [PERIOD_W-1:0] cfg_wdata = '0;
    logic                done;
    logic                expired;
    logic [CLASS_W-1:0]  chosen_class;
    logic                class_changed;

    // predicted block state
    logic [WEIGHT_W-1:0] weights [NUM_CLASSES];
    logic [CLASS_W-1:0]  cur_class;
    logic [PERIOD_W-1:0] tick_cnt;
    logic [PERIOD_W-1:0] tick_period;

    sel_cmd_t cmd_q[$];
    outcome_t outcome_q[$];
    sel_cmd_t cur_cmd;
    outcome_t want;
    int       issued_count = 0;
    int       accepted_count = 0;
    int       errors = 0;
    bit       steady = 1'b0;

    timed_weighted_random_selector #(.NUM_CLASSES(NUM_CLASSES)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .weight_index  (weight_index),
        .weight_value  (weight_value),
        .random_word   (random_word),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .expired       (expired),
        .chosen_class  (chosen_class),
        .class_changed (class_changed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTED)
            $display("%0t mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // advance the predicted state by one command and return the beat it yields
    function automatic outcome_t roulette_step(input sel_cmd_t c);
        outcome_t            o;
        logic [PERIOD_W:0]   nxt;
        logic [31:0]         sum;
        logic [31:0]         acc;
        logic [31:0]         r;
        logic [CLASS_W-1:0]  pick;
        bit                  found;
        o.expired = 1'b0;
        o.changed = 1'b0;
        case (c.kind)
            KIND_TICK:
            begin
                nxt = {1'b0, tick_cnt} + 1'b1;
                if (nxt >= {1'b0, tick_period})
                begin
                    tick_cnt = '0;
                    o.expired = 1'b1;
                    sum = 0;
                    for (int i = 0; i < NUM_CLASSES; i++)
                        sum += weights[i];
                    pick = '0;
                    if (sum != 0)
                    begin
                        r = c.rnd % sum;
                        acc = 0;
                        found = 1'b0;
                        // first nonzero class whose running sum reaches the draw
                        for (int i = 0; i < NUM_CLASSES; i++)
                        begin
                            if (!found && weights[i] != 0)
                            begin
                                acc += weights[i];
                                if (r <= acc)
                                begin
                                    pick = CLASS_W'(i);
                                    found = 1'b1;
                                end
                            end
                        end
                    end
                    o.changed = (pick != cur_class);
                    cur_class = pick;
                end
                else
                    tick_cnt = nxt[PERIOD_W-1:0];
            end
            KIND_SET:
            begin
                if (c.idx < NUM_CLASSES)
                    weights[c.idx] = c.wval;
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < NUM_CLASSES; i++)
                    weights[i] = '0;
            end
            default: ;
        endcase
        o.cls = cur_class;
        return o;
    endfunction

    task automatic push_cmd(input logic [KIND_W-1:0] k, input logic [INDEX_W-1:0] ix,
                            input logic [WEIGHT_W-1:0] v, input logic [RAND_W-1:0] rw);
        sel_cmd_t c;
        c.kind = k;
        c.idx = ix;
        c.wval = v;
        c.rnd = rw;
        cmd_q.push_back(c);
        issued_count++;
    endtask

    task automatic queue_random(input int count);
        int                  p;
        logic [KIND_W-1:0]   k;
        logic [INDEX_W-1:0]  ix;
        logic [WEIGHT_W-1:0] v;
        logic [RAND_W-1:0]   rw;
        for (int n = 0; n < count; n++)
        begin
            p = $urandom_range(0, 99);
            if (p < 58)
                k = KIND_TICK;
            else if (p < 88)
                k = KIND_SET;
            else if (p < 92)
                k = KIND_CLEAR;
            else
                k = KIND_NONE;
            if ($urandom_range(0, 9) == 0)
                ix = INDEX_W'($urandom_range(NUM_CLASSES, 31));
            else
                ix = INDEX_W'($urandom_range(0, NUM_CLASSES - 1));
            // small weights make the draw land on a running-sum boundary often
            case ($urandom_range(0, 3))
                0: v = '0;
                1: v = WEIGHT_W'($urandom_range(1, 4));
                2: v = $urandom_range(0, 1) ? 16'hFFFF : WEIGHT_UNIT;
                default: v = WEIGHT_W'($urandom());
            endcase
            if ($urandom_range(0, 4) == 0)
                rw = RAND_W'($urandom_range(0, 20));
            else
                rw = $urandom();
            push_cmd(k, ix, v, rw);
        end
    endtask

    // holds until every queued command is taken and every beat has come back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (accepted_count != issued_count || outcome_q.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        tick_period = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // driver: one beat offered per command, held while the block is busy
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                outcome_q.push_back(roulette_step(cur_cmd));
                accepted_count++;
            end
            if (!(start && busy))
            begin
                if (cmd_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    cur_cmd = cmd_q.pop_front();
                    start <= 1'b1;
                    kind <= cur_cmd.kind;
                    weight_index <= cur_cmd.idx;
                    weight_value <= cur_cmd.wval;
                    random_word <= cur_cmd.rnd;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
                report_mismatch($sformatf("result beat with nothing expected, class %0d",
                                          chosen_class));
            else
            begin
                want = outcome_q.pop_front();
                if (expired !== want.expired)
                    report_mismatch($sformatf("expired %b, expected %b", expired, want.expired));
                if (chosen_class !== want.cls)
                    report_mismatch($sformatf("chosen_class %0d, expected %0d",
                                              chosen_class, want.cls));
                if (class_changed !== want.changed)
                    report_mismatch($sformatf("class_changed %b, expected %b",
                                              class_changed, want.changed));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [PERIOD_W-1:0] periods [10];
        for (int i = 0; i < NUM_CLASSES; i++)
            weights[i] = '0;
        weights[0] = WEIGHT_UNIT;
        cur_class = '0;
        tick_cnt = '0;
        tick_period = PERIOD_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset period: ticks only count, out-of-range sets and the unused kind do nothing
        push_cmd(KIND_TICK, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
        push_cmd(KIND_SET, 5'd18, 16'hFFFF, 32'h0);
        push_cmd(KIND_SET, 5'd19, 16'd7, 32'h0);
        push_cmd(KIND_SET, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
        push_cmd(KIND_NONE, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
        push_cmd(KIND_TICK, 5'd0, 16'h0, 32'h0);
        wait_drained();

        // zero period: every tick ends a period
        write_period(16'd0);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'd0);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'hFFFF_FFFF);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'd1000);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'd1001);
        push_cmd(KIND_CLEAR, 5'd18, 16'hFFFF, 32'hFFFF_FFFF);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'h1234_5678);
        push_cmd(KIND_SET, 5'd5, 16'd1, 32'd0);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'hFFFF_FFFF);
        push_cmd(KIND_SET, 5'd3, 16'd2, 32'd0);
        push_cmd(KIND_SET, 5'd5, 16'd0, 32'd0);
        push_cmd(KIND_SET, 5'd9, 16'd2, 32'd0);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'd2);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'd3);
        wait_drained();

        // long period, a few ticks, then lower the period below the count
        write_period(16'hFFFF);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'd0);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'd0);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'd0);
        wait_drained();
        write_period(16'd2);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'd1);
        push_cmd(KIND_TICK, 5'd0, 16'd0, 32'd1);
        wait_drained();

        periods[0] = 16'd1;
        periods[1] = 16'd0;
        periods[2] = 16'd2;
        periods[3] = 16'd3;
        periods[4] = 16'hFFFF;
        periods[5] = PERIOD_W'($urandom_range(4, 12));
        periods[6] = 16'd1;
        periods[7] = PERIOD_W'($urandom_range(1, 5));
        periods[8] = 16'd2;
        periods[9] = PERIOD_W'($urandom_range(1, 3));
        for (int ph = 0; ph < 10; ph++)
        begin
            write_period(periods[ph]);
            steady = (ph == 3);
            queue_random(100);
            wait_drained();
        end
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
